// File: sv/lfpwm_pkg.sv
// Package: shared types and constants of the candle-flicker LED driver.
`timescale 1ns / 1ps
`default_nettype none
package lfpwm_pkg;

	localparam int unsigned SEED_W = 16;
	localparam int unsigned WAIT_W = 17;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WAIT = 1'd1;

	localparam logic [SEED_W-1:0] SEED_RESET = 16'hACE1;
	localparam logic [WAIT_W-1:0] WAIT_RESET = 17'd99999;

	localparam logic [1:0] PHASE_CODE_WAIT = 2'd0;
	localparam logic [1:0] PHASE_CODE_FADE = 2'd1;
	localparam logic [1:0] PHASE_CODE_RED = 2'd2;
	localparam logic [1:0] PHASE_CODE_YELLOW = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT   = 4'b0001,
		PH_FADE   = 4'b0010,
		PH_RED    = 4'b0100,
		PH_YELLOW = 4'b1000
	} phase_t;

endpackage
`default_nettype wire

// File: sv/lfpwm_if.sv
// Interfaces: tick, result and configuration channels with valid/ready handshakes.
`timescale 1ns / 1ps
`default_nettype none
interface lfpwm_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface lfpwm_result_if;
	logic       valid;
	logic       ready;
	logic       red_level;
	logic       yellow_level;
	logic [1:0] phase_now;

	modport source (output valid, output red_level, output yellow_level, output phase_now,
		input ready);
	modport sink (input valid, input red_level, input yellow_level, input phase_now,
		output ready);
endinterface

interface lfpwm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lfpwm_pkg::CFG_IDX_W-1:0]  idx;
	logic [lfpwm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

// File: sv/lfsr_flicker_led_pwm.sv
// Top level: candle-flicker LED driver with fade-in and LFSR-driven red/yellow bursts.
`timescale 1ns / 1ps
`default_nettype none
// One word in, one word out: each accepted tick word yields the pin levels and phase of
// the tick the block stands at, and a tick of 1 then advances the sequence. A word is
// taken every cycle; its result is registered in the output register, and
// the input stalls only while that register is full and the result side is not ready.
// Configuration writes are always accepted and act at once; lfsr_seed is used when the
// fade-in ends, startup_wait bounds the dark interval after reset.
module lfsr_flicker_led_pwm (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lfpwm_tick_if.sink        ticks,
	lfpwm_result_if.source    levels,
	lfpwm_cfg_if.sink         cfg
);
	import lfpwm_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [WAIT_W-1:0] startup_wait_q;

	phase_t            phase_q;
	logic [15:0]       shift_q;
	logic [WAIT_W-1:0] wait_count_q;
	logic [7:0]        ramp_q;
	logic [7:0]        repeats_q;
	logic [9:0]        half_q;
	logic              second_q;
	logic [7:0]        bright_q;

	logic       out_valid_q;
	logic       red_q;
	logic       yellow_q;
	logic [1:0] code_q;

	phase_t      ph;
	logic [7:0]  ramp;
	logic [7:0]  repeats;
	logic [9:0]  half;
	logic        second;
	phase_t      ph_n;
	logic [15:0] shift_n;
	logic [WAIT_W-1:0] wait_n;
	logic [7:0]  ramp_n;
	logic [7:0]  repeats_n;
	logic [9:0]  half_n;
	logic        second_n;
	logic [7:0]  bright_n;
	logic [9:0]  len;
	logic [15:0] lfsr_src;
	logic [15:0] lfsr_nxt;
	logic        red_d;
	logic        yellow_d;
	logic [1:0]  code_d;
	logic        accept;

	assign cfg.ready    = 1'b1;
	assign ticks.ready  = !out_valid_q || levels.ready;
	assign accept       = ticks.valid && ticks.ready;

	assign levels.valid        = out_valid_q;
	assign levels.red_level    = red_q;
	assign levels.yellow_level = yellow_q;
	assign levels.phase_now    = code_q;

	always_comb begin
		ph      = phase_q;
		ramp    = ramp_q;
		repeats = repeats_q;
		half    = half_q;
		second  = second_q;
		if (phase_q == PH_WAIT && wait_count_q >= startup_wait_q) begin
			ph      = PH_FADE;
			ramp    = '0;
			repeats = 8'd1;
			half    = '0;
			second  = 1'b0;
		end

		unique case (ph)
			PH_WAIT: begin
				red_d    = 1'b0;
				yellow_d = 1'b0;
				code_d   = PHASE_CODE_WAIT;
				len      = 10'd1;
			end
			PH_FADE: begin
				red_d    = !second;
				yellow_d = !second;
				code_d   = PHASE_CODE_FADE;
				len      = second ? 10'd256 - {2'b00, ramp} : {2'b00, ramp} + 10'd1;
			end
			PH_RED: begin
				red_d    = second;
				yellow_d = 1'b0;
				code_d   = PHASE_CODE_RED;
				len      = second ? 10'd256 - {2'b00, bright_q}
					: {2'b00, bright_q} + 10'd128;
			end
			PH_YELLOW: begin
				red_d    = 1'b1;
				yellow_d = !second;
				code_d   = PHASE_CODE_YELLOW;
				len      = second ? 10'd512 - {2'b00, bright_q} : {2'b00, bright_q} + 10'd1;
			end
			default: begin
				red_d    = 1'b0;
				yellow_d = 1'b0;
				code_d   = PHASE_CODE_WAIT;
				len      = 10'd1;
			end
		endcase

		lfsr_src = (ph == PH_FADE) ? seed_q : shift_q;
		lfsr_nxt = {lfsr_src[0] ^ lfsr_src[2] ^ lfsr_src[3] ^ lfsr_src[5], lfsr_src[15:1]};

		ph_n      = ph;
		shift_n   = shift_q;
		wait_n    = wait_count_q;
		ramp_n    = ramp;
		repeats_n = repeats;
		half_n    = half;
		second_n  = second;
		bright_n  = bright_q;

		if (ph == PH_WAIT) begin
			wait_n = wait_count_q + 1'b1;
		end else if (half + 10'd1 < len) begin
			half_n = half + 10'd1;
		end else if (!second) begin
			half_n   = '0;
			second_n = 1'b1;
		end else if (repeats != 8'd0) begin
			half_n    = '0;
			second_n  = 1'b0;
			repeats_n = repeats - 8'd1;
		end else if (ph == PH_FADE && ramp != 8'd255) begin
			half_n    = '0;
			second_n  = 1'b0;
			ramp_n    = ramp + 8'd1;
			repeats_n = 8'd1;
		end else begin
			ph_n      = (ph == PH_RED) ? PH_YELLOW : PH_RED;
			shift_n   = lfsr_nxt;
			repeats_n = lfsr_nxt[10:3];
			bright_n  = lfsr_nxt[14:7];
			half_n    = '0;
			second_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= SEED_RESET;
			startup_wait_q <= WAIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				CFG_LFSR_SEED:    seed_q         <= cfg.data[SEED_W-1:0];
				CFG_STARTUP_WAIT: startup_wait_q <= cfg.data[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			shift_q      <= SEED_RESET;
			wait_count_q <= '0;
			ramp_q       <= '0;
			repeats_q    <= '0;
			half_q       <= '0;
			second_q     <= 1'b0;
			bright_q     <= '0;
		end else if (accept && ticks.tick) begin
			phase_q      <= ph_n;
			shift_q      <= shift_n;
			wait_count_q <= wait_n;
			ramp_q       <= ramp_n;
			repeats_q    <= repeats_n;
			half_q       <= half_n;
			second_q     <= second_n;
			bright_q     <= bright_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (levels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_q    <= red_d;
			yellow_q <= yellow_d;
			code_q   <= code_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/lfpwm_chk.sv
// Checker: port-level assertions on the candle-flicker LED driver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lfpwm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       red,
	input wire logic       yellow,
	input wire logic [1:0] phase_now
);
	import lfpwm_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(yellow)
			&& $stable(phase_now))
		else $error("result word changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word gave no result");

	a_pin_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(phase_now != PHASE_CODE_WAIT || (!red && !yellow))
			&& (phase_now != PHASE_CODE_FADE || red == yellow)
			&& (phase_now != PHASE_CODE_RED || !yellow)
			&& (phase_now != PHASE_CODE_YELLOW || red))
		else $error("pin levels do not fit the phase");

endmodule

bind lfsr_flicker_led_pwm lfpwm_chk u_lfpwm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (ticks.valid),
	.in_ready  (ticks.ready),
	.out_valid (levels.valid),
	.out_ready (levels.ready),
	.red       (levels.red_level),
	.yellow    (levels.yellow_level),
	.phase_now (levels.phase_now)
);
`default_nettype wire
